### rtl/core/gwnc_pkg.sv
// gwnc_pkg: shared types, constants and helpers for the 3D gridding window counter.
// Used by every module under rtl/core; depends on nothing.
package gwnc_pkg;

	localparam int FRAC_BITS  = 10;
	localparam int MAX_WINDOW = 8;
	localparam int MAX_GRID   = 1024;

	localparam logic [1:0] REG_GRID_X = 2'd0;
	localparam logic [1:0] REG_GRID_Y = 2'd1;
	localparam logic [1:0] REG_GRID_Z = 2'd2;
	localparam logic [1:0] REG_WINDOW = 2'd3;

	typedef struct packed {
		logic signed [23:0] coord_x;
		logic signed [23:0] coord_y;
		logic signed [23:0] coord_z;
		logic               last_point;
	} in_word_t;

	typedef struct packed {
		logic [9:0]  point_count;
		logic [47:0] total_count;
		logic        run_end;
	} out_word_t;

	typedef struct packed {
		logic [10:0] grid_size_x;
		logic [10:0] grid_size_y;
		logic [10:0] grid_size_z;
		logic [3:0]  window_width;
	} cfg_t;

	// center index and remainder of one axis
	typedef struct packed {
		logic signed [14:0] c;
		logic signed [12:0] r;
	} axis_t;

	typedef struct packed {
		axis_t x;
		axis_t y;
		axis_t z;
		logic  last;
	} job_t;

	function automatic logic [3:0] clamp_window(input logic [3:0] ww);
		return (ww > 4'(MAX_WINDOW)) ? 4'(MAX_WINDOW) : ww;
	endfunction

	function automatic logic [10:0] clamp_grid(input logic [10:0] g);
		return (g > 11'(MAX_GRID)) ? 11'(MAX_GRID) : g;
	endfunction

endpackage

### rtl/core/gwnc_front.sv
// gwnc_front: accepts points, splits each axis into center and remainder,
// and holds the jobs in a four-entry queue for the back end. Uses gwnc_pkg.
module gwnc_front import gwnc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     push,
	output logic     full,
	input  in_word_t in_word,
	output logic     job_valid,
	output job_t     job,
	input  logic     job_pop
);

	localparam logic signed [24:0] HALF = 25'sd1 <<< (FRAC_BITS - 1);

	job_t       mem_q [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] cnt_q;
	logic [3:0] w;
	logic       wr_en;
	logic       rd_en;
	job_t       job_in;

	function automatic axis_t split_axis(input logic signed [23:0] t,
			input logic odd);
		logic signed [24:0] t25;
		logic signed [24:0] s;
		logic [24:0]        mag;
		logic signed [14:0] q;
		logic signed [14:0] c;
		logic signed [24:0] cw;
		logic signed [24:0] rr;
		axis_t              a;
		t25 = 25'(t);
		s   = t25 + (odd ? HALF : 25'sd0);
		mag = s[24] ? 25'(-s) : 25'(s);
		q   = 15'(mag >> FRAC_BITS);
		c   = s[24] ? -q : q;
		cw  = 25'(c);
		rr  = t25 - (cw <<< FRAC_BITS);
		a.c = c;
		a.r = rr[12:0];
		return a;
	endfunction

	assign w = clamp_window(cfg.window_width);

	always_comb begin
		job_in.x    = split_axis(in_word.coord_x, w[0]);
		job_in.y    = split_axis(in_word.coord_y, w[0]);
		job_in.z    = split_axis(in_word.coord_z, w[0]);
		job_in.last = in_word.last_point;
	end

	assign full      = (cnt_q == 3'd4);
	assign job_valid = (cnt_q != 3'd0);
	assign job       = mem_q[rd_ptr_q];
	assign wr_en     = push && !full;
	assign rd_en     = job_pop && job_valid;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= job_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= wr_ptr_q + 2'd1;
			if (rd_en) rd_ptr_q <= rd_ptr_q + 2'd1;
			case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + 3'd1;
				2'b01:   cnt_q <= cnt_q - 3'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### rtl/core/gwnc_back.sv
// gwnc_back: walks the window of one job node by node through a three-stage
// distance pipeline, counts hits and keeps the run total. Uses gwnc_pkg.
module gwnc_back import gwnc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      job_valid,
	input  job_t      job,
	output logic      job_pop,
	input  logic      res_full,
	output logic      res_push,
	output out_word_t res_word
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]  state_q;
	job_t        job_q;
	logic [2:0]  ix_q, iy_q, iz_q;
	logic [9:0]  count_q;
	logic [47:0] total_q;

	logic [3:0]  w;
	logic [2:0]  wm1;
	logic [2:0]  h;
	logic [26:0] limit;
	logic [10:0] size_x, size_y, size_z;
	logic        last_node;

	logic signed [3:0]  ux, uy, uz;
	logic signed [13:0] dx, dy, dz;
	logic               inb;

	logic               v_s1, v_s2;
	logic signed [13:0] dx_s1, dy_s1, dz_s1;
	logic               inb_s1;
	logic [24:0]        sx_s2, sy_s2, sz_s2;
	logic               inb_s2;
	logic [26:0]        dsq;
	logic [48:0]        sum;

	function automatic logic signed [3:0] offset(input logic [2:0] i,
			input logic [2:0] hh);
		return $signed({1'b0, i}) - $signed({1'b0, hh});
	endfunction

	function automatic logic signed [13:0] delta(input logic signed [12:0] r,
			input logic signed [3:0] u);
		logic signed [13:0] uw;
		uw = 14'(u) <<< FRAC_BITS;
		return 14'(r) - uw;
	endfunction

	function automatic logic in_grid(input logic signed [14:0] c,
			input logic signed [3:0] u, input logic [10:0] size);
		logic signed [15:0] n;
		n = 16'(c) - 16'sd1 + 16'(u);
		return !n[15] && (n[14:0] < 15'(size));
	endfunction

	function automatic logic [24:0] square(input logic signed [13:0] d);
		logic signed [27:0] p;
		p = d * d;
		return p[24:0];
	endfunction

	assign w      = clamp_window(cfg.window_width);
	assign wm1    = 3'(w - 4'd1);
	assign h      = w[0] ? 3'((w - 4'd1) >> 1) : 3'((w >> 1) - 4'd1);
	assign limit  = 27'({3'd0, w} * {3'd0, w}) << (2 * FRAC_BITS - 2);
	assign size_x = clamp_grid(cfg.grid_size_x);
	assign size_y = clamp_grid(cfg.grid_size_y);
	assign size_z = clamp_grid(cfg.grid_size_z);

	assign ux = offset(ix_q, h);
	assign uy = offset(iy_q, h);
	assign uz = offset(iz_q, h);
	assign dx = delta(job_q.x.r, ux);
	assign dy = delta(job_q.y.r, uy);
	assign dz = delta(job_q.z.r, uz);
	assign inb = in_grid(job_q.x.c, ux, size_x) && in_grid(job_q.y.c, uy, size_y)
		&& in_grid(job_q.z.c, uz, size_z);
	assign last_node = (ix_q == wm1) && (iy_q == wm1) && (iz_q == wm1);

	assign dsq = 27'(sx_s2) + 27'(sy_s2) + 27'(sz_s2);
	assign sum = {1'b0, total_q} + 49'(count_q);

	assign job_pop  = (state_q == ST_IDLE) && job_valid;
	assign res_push = (state_q == ST_DONE) && !res_full;

	always_comb begin
		res_word.point_count = count_q;
		res_word.total_count = sum[48] ? '1 : sum[47:0];
		res_word.run_end     = job_q.last;
	end

	always_ff @(posedge clk) begin
		if (job_pop) job_q <= job;
		dx_s1  <= dx;
		dy_s1  <= dy;
		dz_s1  <= dz;
		inb_s1 <= inb;
		sx_s2  <= square(dx_s1);
		sy_s2  <= square(dy_s1);
		sz_s2  <= square(dz_s1);
		inb_s2 <= inb_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ix_q    <= '0;
			iy_q    <= '0;
			iz_q    <= '0;
			count_q <= '0;
			total_q <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_RUN);
			v_s2 <= v_s1;
			if (v_s2 && inb_s2 && (dsq < limit)) count_q <= count_q + 10'd1;
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						ix_q    <= '0;
						iy_q    <= '0;
						iz_q    <= '0;
						count_q <= '0;
						state_q <= (w == 4'd0) ? ST_DRAIN : ST_RUN;
					end
				end
				ST_RUN: begin
					if (last_node) begin
						state_q <= ST_DRAIN;
					end else if (ix_q != wm1) begin
						ix_q <= ix_q + 3'd1;
					end else begin
						ix_q <= '0;
						if (iy_q != wm1) begin
							iy_q <= iy_q + 3'd1;
						end else begin
							iy_q <= '0;
							iz_q <= iz_q + 3'd1;
						end
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!res_full) begin
						total_q <= job_q.last ? '0 : res_word.total_count;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### rtl/core/gwnc_oq.sv
// gwnc_oq: two-entry result queue between the back end and the output port.
// Uses gwnc_pkg for the result word type.
module gwnc_oq import gwnc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr,
	input  out_word_t wr_word,
	output logic      full,
	input  logic      pop,
	output logic      empty,
	output out_word_t out_word
);

	out_word_t  mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       wr_en;
	logic       rd_en;

	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign out_word = mem_q[rd_ptr_q];
	assign wr_en    = wr && !full;
	assign rd_en    = pop && !empty;

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_ptr_q] <= wr_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= !wr_ptr_q;
			if (rd_en) rd_ptr_q <= !rd_ptr_q;
			case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### rtl/core/gridding_window_neighbor_count_3d.sv
// gridding_window_neighbor_count_3d: top level with the configuration registers.
// Instantiates gwnc_front, gwnc_back and gwnc_oq; uses gwnc_pkg.
//
// Input channel: a point word (three 24-bit coordinates with 10 fraction bits
// and a last-point flag) is taken at a clock edge with push high and full low.
// A four-word queue sits behind the input, so several points can be pushed
// while one is being worked on.
// Output channel: the oldest result word is shown while empty is low and is
// taken at an edge with pop high. Results leave in input order, one per point.
// Timing: the back end tests one window node per cycle and takes the next point
// only after the result of the current one has gone into the result queue.
// If pop stays low, the two-word result queue fills, then the back end holds,
// then the input queue fills and full rises; nothing is dropped.
// Reset clears the queues, the running total and the sequencer; registers go
// to grid 64 x 64 x 64 and window width 3. Registers sit at byte addresses
// 0, 4, 8, 12 and may be written only while no point is in flight.
module gridding_window_neighbor_count_3d import gwnc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        push,
	output logic        full,
	input  in_word_t    in_word,
	input  logic        pop,
	output logic        empty,
	output out_word_t   out_word
);

	cfg_t      cfg_q;
	logic      job_valid;
	job_t      job;
	logic      job_pop;
	logic      res_full;
	logic      res_push;
	out_word_t res_word;
	logic      reg_wr;

	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_size_x  <= 11'd64;
			cfg_q.grid_size_y  <= 11'd64;
			cfg_q.grid_size_z  <= 11'd64;
			cfg_q.window_width <= 4'd3;
		end else if (reg_wr) begin
			case (paddr[3:2])
				REG_GRID_X: cfg_q.grid_size_x  <= pwdata[10:0];
				REG_GRID_Y: cfg_q.grid_size_y  <= pwdata[10:0];
				REG_GRID_Z: cfg_q.grid_size_z  <= pwdata[10:0];
				REG_WINDOW: cfg_q.window_width <= pwdata[3:0];
				default:    cfg_q              <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_GRID_X: prdata = 32'(cfg_q.grid_size_x);
			REG_GRID_Y: prdata = 32'(cfg_q.grid_size_y);
			REG_GRID_Z: prdata = 32'(cfg_q.grid_size_z);
			REG_WINDOW: prdata = 32'(cfg_q.window_width);
			default:    prdata = '0;
		endcase
	end

	gwnc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.push      (push),
		.full      (full),
		.in_word   (in_word),
		.job_valid (job_valid),
		.job       (job),
		.job_pop   (job_pop)
	);

	gwnc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_valid (job_valid),
		.job       (job),
		.job_pop   (job_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_word  (res_word)
	);

	gwnc_oq u_oq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (res_push),
		.wr_word  (res_word),
		.full     (res_full),
		.pop      (pop),
		.empty    (empty),
		.out_word (out_word)
	);

endmodule

### sim/gridding_window_neighbor_count_3d_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for gridding_window_neighbor_count_3d: drives trajectory points,
// writes the grid and window registers over APB, and checks every result word.
// Depends on gwnc_pkg and the RTL under rtl/core only.
module gridding_window_neighbor_count_3d_tb;
	import gwnc_pkg::*;

	localparam int ONE            = 1 << FRAC_BITS;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int DRAIN_CYCLES   = 600;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        push = 1'b0;
	logic        full;
	in_word_t    in_word = '0;
	logic        pop = 1'b0;
	logic        empty;
	out_word_t   out_word;

	cfg_t        cfg_shadow = '{11'd64, 11'd64, 11'd64, 4'd3};
	logic [47:0] run_total = '0;
	out_word_t   pending_results[$];
	bit          idle_en = 1'b1;
	int          pop_hold = 0;
	int          quiet_cycles = 0;
	int          errors = 0;
	int          n_points = 0;
	int          n_results = 0;
	int          n_run_ends = 0;
	int          n_settings = 0;

	gridding_window_neighbor_count_3d u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.push     (push),
		.full     (full),
		.in_word  (in_word),
		.pop      (pop),
		.empty    (empty),
		.out_word (out_word)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// center and remainder along one axis
	function automatic void axis_split(input longint t, input longint shift,
			output longint c, output longint r);
		longint s;
		s = t + shift;
		c = (s >= 0) ? (s >> FRAC_BITS) : -((-s) >> FRAC_BITS);
		r = t - c * ONE;
	endfunction

	function automatic int unsigned window_hits(input in_word_t p);
		longint w, h, shift, lim;
		longint sx, sy, sz, cx, cy, cz, rx, ry, rz;
		longint ux, uy, uz, nx, ny, nz, dx, dy, dz;
		int unsigned hits;
		hits = 0;
		w = (cfg_shadow.window_width > MAX_WINDOW) ? MAX_WINDOW : cfg_shadow.window_width;
		h = w[0] ? (w - 1) / 2 : w / 2 - 1;
		shift = w[0] ? (ONE >> 1) : 0;
		lim = w * w * ONE * ONE;
		sx = (cfg_shadow.grid_size_x > MAX_GRID) ? MAX_GRID : cfg_shadow.grid_size_x;
		sy = (cfg_shadow.grid_size_y > MAX_GRID) ? MAX_GRID : cfg_shadow.grid_size_y;
		sz = (cfg_shadow.grid_size_z > MAX_GRID) ? MAX_GRID : cfg_shadow.grid_size_z;
		axis_split(longint'($signed(p.coord_x)), shift, cx, rx);
		axis_split(longint'($signed(p.coord_y)), shift, cy, ry);
		axis_split(longint'($signed(p.coord_z)), shift, cz, rz);
		for (uz = -h; uz < w - h; uz++) begin
			nz = cz - 1 + uz;
			if (nz < 0 || nz >= sz) continue;
			dz = rz - uz * ONE;
			for (uy = -h; uy < w - h; uy++) begin
				ny = cy - 1 + uy;
				if (ny < 0 || ny >= sy) continue;
				dy = ry - uy * ONE;
				for (ux = -h; ux < w - h; ux++) begin
					nx = cx - 1 + ux;
					if (nx < 0 || nx >= sx) continue;
					dx = rx - ux * ONE;
					if (4 * (dx * dx + dy * dy + dz * dz) < lim) hits++;
				end
			end
		end
		return (hits > 1023) ? 1023 : hits;
	endfunction

	function automatic in_word_t point(input int x, input int y, input int z, input bit last);
		in_word_t p;
		p.coord_x = 24'(x);
		p.coord_y = 24'(y);
		p.coord_z = 24'(z);
		p.last_point = last;
		return p;
	endfunction

	// send one point word, then record the result it should produce
	task automatic send_point(input in_word_t p);
		out_word_t want;
		logic [48:0] sum;
		if (idle_en && $urandom_range(0, 4) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		push <= 1'b1;
		in_word <= p;
		do @(posedge clk); while (full);
		want.point_count = 10'(window_hits(p));
		sum = {1'b0, run_total} + want.point_count;
		want.total_count = sum[48] ? 48'hFFFF_FFFF_FFFF : sum[47:0];
		want.run_end = p.last_point;
		run_total = p.last_point ? '0 : want.total_count;
		pending_results.push_back(want);
		n_points++;
		if (p.last_point) n_run_ends++;
	endtask

	task automatic wait_idle();
		push <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_GRID_X: cfg_shadow.grid_size_x = val[10:0];
			REG_GRID_Y: cfg_shadow.grid_size_y = val[10:0];
			REG_GRID_Z: cfg_shadow.grid_size_z = val[10:0];
			REG_WINDOW: cfg_shadow.window_width = val[3:0];
			default: ;
		endcase
	endtask

	// upper bits of pwdata carry junk
	task automatic apply_settings(input cfg_t c);
		logic [31:0] v;
		wait_idle();
		v = $urandom(); v[10:0] = c.grid_size_x; reg_write(REG_GRID_X, v);
		v = $urandom(); v[10:0] = c.grid_size_y; reg_write(REG_GRID_Y, v);
		v = $urandom(); v[10:0] = c.grid_size_z; reg_write(REG_GRID_Z, v);
		v = $urandom(); v[3:0] = c.window_width; reg_write(REG_WINDOW, v);
		n_settings++;
	endtask

	function automatic logic [10:0] pick_grid();
		case ($urandom_range(0, 19))
			0:       return 11'd0;
			1:       return 11'd2047;
			2, 3, 4, 5, 6, 7, 8, 9, 10, 11: return 11'($urandom_range(1, 16));
			default: return 11'($urandom_range(1, 2047));
		endcase
	endfunction

	function automatic logic [23:0] rand_coord(input logic [10:0] g);
		int gc;
		gc = (g > MAX_GRID) ? MAX_GRID : int'(g);
		case ($urandom_range(0, 19))
			0, 1:    return 24'($urandom());
			2, 3, 4: return 24'(int'($urandom_range(0, gc + 2)) * ONE
				+ int'($urandom_range(0, 2)) - 1 + ($urandom_range(0, 1) ? ONE / 2 : 0));
			default: return 24'(int'($urandom_range(0, (gc + 4) * ONE)) - 2 * ONE);
		endcase
	endfunction

	task automatic send_random_points(input int count);
		in_word_t p;
		for (int i = 0; i < count; i++) begin
			if (i == count / 2) wait_idle();
			p.coord_x = rand_coord(cfg_shadow.grid_size_x);
			p.coord_y = rand_coord(cfg_shadow.grid_size_y);
			p.coord_z = rand_coord(cfg_shadow.grid_size_z);
			p.last_point = ($urandom_range(0, 9) == 0);
			send_point(p);
		end
	endtask

	task automatic test_reset_settings();
		send_point(point(ONE, ONE, ONE, 1'b0));
		send_point(point(32 * ONE + ONE / 2, 32 * ONE + ONE / 4, -ONE / 2, 1'b0));
		send_point(point(64 * ONE, 63 * ONE + ONE / 2 - 1, 20 * ONE + 1, 1'b0));
		send_point(point(10 * ONE, 10 * ONE, 10 * ONE, 1'b1));
	endtask

	task automatic test_coord_extremes();
		send_point(point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b0));
		send_point(point(24'h800000, 24'h800000, 24'h800000, 1'b0));
		send_point(point(0, 0, 0, 1'b0));
		send_point(point(-1, 24'h7FFFFF, 24'h800000, 1'b1));
	endtask

	task automatic test_window_widths();
		apply_settings('{11'd64, 11'd64, 11'd64, 4'd0});
		send_point(point(5 * ONE, 5 * ONE, 5 * ONE, 1'b0));
		apply_settings('{11'd64, 11'd64, 11'd64, 4'd1});
		send_point(point(5 * ONE + ONE / 2, 5 * ONE + ONE / 2 - 1, 5 * ONE, 1'b0));
		apply_settings('{11'd64, 11'd64, 11'd64, 4'd2});
		send_point(point(5 * ONE + ONE / 2, 5 * ONE, 5 * ONE + 3, 1'b0));
		apply_settings('{11'd64, 11'd64, 11'd64, 4'd8});
		send_point(point(30 * ONE + 100, 30 * ONE, 2 * ONE, 1'b0));
		send_point(point(30 * ONE + ONE / 2, 30 * ONE + ONE / 2, 30 * ONE + ONE / 2, 1'b0));
		apply_settings('{11'd64, 11'd64, 11'd64, 4'd15});
		send_point(point(30 * ONE, 30 * ONE, 30 * ONE, 1'b1));
	endtask

	task automatic test_grid_sizes();
		apply_settings('{11'd0, 11'd64, 11'd64, 4'd3});
		send_point(point(ONE, ONE, ONE, 1'b0));
		apply_settings('{11'd1, 11'd1, 11'd1, 4'd3});
		send_point(point(ONE, ONE, ONE, 1'b0));
		send_point(point(ONE + ONE / 2, ONE / 2, ONE, 1'b0));
		apply_settings('{11'd2047, 11'd2047, 11'd2047, 4'd3});
		send_point(point(1024 * ONE, 1024 * ONE + ONE / 2, 1023 * ONE, 1'b0));
	endtask

	task automatic test_run_end();
		send_point(point(2 * ONE, 2 * ONE, 2 * ONE, 1'b1));
		send_point(point(3 * ONE, 3 * ONE, 3 * ONE, 1'b1));
		send_point(point(4 * ONE, 4 * ONE, 4 * ONE, 1'b0));
	endtask

	task automatic test_random_settings();
		for (int ph = 0; ph < 6; ph++) begin
			apply_settings('{pick_grid(), pick_grid(), pick_grid(), 4'($urandom_range(0, 6))});
			send_random_points(230);
		end
	endtask

	task automatic test_wide_windows();
		apply_settings('{pick_grid(), pick_grid(), pick_grid(), 4'd8});
		send_random_points(35);
		apply_settings('{pick_grid(), pick_grid(), pick_grid(), 4'($urandom_range(9, 15))});
		send_random_points(35);
	endtask

	task automatic test_no_idling();
		wait_idle();
		idle_en = 1'b0;
		apply_settings('{11'($urandom_range(4, 40)), 11'($urandom_range(4, 40)),
			11'($urandom_range(4, 40)), 4'($urandom_range(1, 4))});
		send_random_points(280);
	endtask

	always @(posedge clk) begin : result_check
		out_word_t want;
		if (arst_n && pop && !empty) begin
			n_results++;
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: unexpected result word count=%0d total=%0d end=%0b",
						out_word.point_count, out_word.total_count, out_word.run_end);
			end else begin
				want = pending_results.pop_front();
				if (out_word.point_count !== want.point_count
						|| out_word.total_count !== want.total_count
						|| out_word.run_end !== want.run_end) begin
					errors++;
					if (errors <= 10)
						$display("ERROR: result %0d: count exp %0d got %0d, total exp %0d got %0d, end exp %0b got %0b",
							n_results, want.point_count, out_word.point_count,
							want.total_count, out_word.total_count,
							want.run_end, out_word.run_end);
				end
			end
		end
		if (pop_hold > 0) begin
			pop <= 1'b0;
			pop_hold <= pop_hold - 1;
		end else if (idle_en && $urandom_range(0, 5) == 0) begin
			pop <= 1'b0;
			pop_hold <= $urandom_range(0, 2);
		end else begin
			pop <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("ERROR: no handshake for %0d cycles", WATCHDOG_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_settings();
		test_coord_extremes();
		test_window_widths();
		test_grid_sizes();
		test_run_end();
		test_random_settings();
		test_wide_windows();
		test_no_idling();
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d points in %0d register settings, %0d run ends; %0d results checked, %0d errors.",
			n_points, n_settings, n_run_ends, n_results, errors);
		if (errors == 0 && pending_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

### sim.f
rtl/core/gwnc_pkg.sv
rtl/core/gwnc_front.sv
rtl/core/gwnc_back.sv
rtl/core/gwnc_oq.sv
rtl/core/gridding_window_neighbor_count_3d.sv
sim/gridding_window_neighbor_count_3d_tb.sv
